/* sv/etok_pkg.sv */
package etok_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKEN_CHARS = 2'd1;

  localparam logic [8:0] MAX_TOKENS_RST      = 9'd256;
  localparam logic [7:0] MAX_TOKEN_CHARS_RST = 8'd63;

  localparam int INQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH = 4;

  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_NAME   = 3'd1;
  localparam logic [2:0] KIND_QUOTED = 3'd2;
  localparam logic [2:0] KIND_SINGLE = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_MANY     = 3'd1;
  localparam logic [2:0] ST_NUM_LONG     = 3'd2;
  localparam logic [2:0] ST_NAME_LONG    = 3'd3;
  localparam logic [2:0] ST_QUOTE_LONG   = 3'd4;
  localparam logic [2:0] ST_UNTERMINATED = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_NAME,
    MODE_QUOTED
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] upper;
    logic       end_of_string;
    logic       is_digit;
    logic       is_alpha;
    logic       is_space;
  } class_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_first;
    logic       token_end;
    logic [2:0] status;
    logic       string_done;
    logic       last_result;
  } result_t;

endpackage

/* sv/etok_front.sv */
module etok_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  etok_pkg::in_item_t    in_item,
  output logic                  item_valid,
  output etok_pkg::class_item_t item,
  input  logic                  item_take
);
  import etok_pkg::*;

  localparam int PW = $clog2(INQ_DEPTH);
  localparam int CW = $clog2(INQ_DEPTH + 1);

  class_item_t         entry [INQ_DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       count;
  class_item_t         cls;
  logic                do_push;
  logic                do_pop;

  always_comb begin
    logic lower;
    lower        = (in_item.ch >= 8'h61) && (in_item.ch <= 8'h7A);
    cls.ch       = in_item.ch;
    cls.end_of_string = in_item.end_of_string;
    cls.is_digit = (in_item.ch >= 8'h30) && (in_item.ch <= 8'h39);
    cls.is_alpha = lower || ((in_item.ch >= 8'h41) && (in_item.ch <= 8'h5A));
    cls.is_space = (in_item.ch == CH_SPACE) || (in_item.ch == CH_TAB) ||
                   (in_item.ch == CH_LF);
    cls.upper    = lower ? (in_item.ch - 8'd32) : in_item.ch;
  end

  assign full       = (count == CW'(INQ_DEPTH));
  assign do_push    = push && !full;
  assign item_valid = (count != '0);
  assign do_pop     = item_take && item_valid;
  assign item       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

/* sv/etok_back.sv */
module etok_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  etok_pkg::class_item_t               item,
  output logic                                item_take,
  input  logic                                cfg_we,
  input  logic [etok_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [etok_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                room,
  output logic [1:0]                          res_n,
  output etok_pkg::result_t                   res0,
  output etok_pkg::result_t                   res1
);
  import etok_pkg::*;

  logic [8:0] max_tokens;
  logic [7:0] max_token_chars;

  lex_mode_t  mode, mode_next;
  logic       quote_is_double, quote_is_double_next;
  logic       exp_last, exp_last_next;
  logic [7:0] held_char, held_char_next;
  logic       held_valid, held_valid_next;
  logic [1:0] held_kind, held_kind_next;
  logic       held_first, held_first_next;
  logic [7:0] token_length, token_length_next;
  logic [8:0] token_count, token_count_next;
  logic [2:0] error_latched, error_latched_next;

  logic       go;
  logic [7:0] lim;
  logic       too_long;
  logic       count_full;
  logic       quote_close;
  logic       num_cont;
  logic       name_cont;
  logic       num_start;
  logic       is_quote;
  result_t    res [2];

  function automatic result_t mk(input logic [2:0] kind, input logic [7:0] c,
                                 input logic valid, input logic first,
                                 input logic tend, input logic [2:0] st,
                                 input logic done);
    result_t r;
    r.token_kind  = kind;
    r.out_char    = c;
    r.char_valid  = valid;
    r.token_first = first;
    r.token_end   = tend;
    r.status      = st;
    r.string_done = done;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic lex_mode_t start_mode(input class_item_t it, input logic full_cnt);
    lex_mode_t m;
    m = MODE_IDLE;
    if (!it.is_space && !full_cnt) begin
      if (it.is_digit || it.ch == CH_DOT) begin
        m = MODE_NUMBER;
      end else if (it.is_alpha) begin
        m = MODE_NAME;
      end else if (it.ch == CH_DQUOTE || it.ch == CH_SQUOTE) begin
        m = MODE_QUOTED;
      end
    end
    return m;
  endfunction

  assign go          = item_valid && room;
  assign item_take   = go;
  assign lim         = (max_token_chars == '0) ? 8'd1 : max_token_chars;
  assign too_long    = (token_length >= lim);
  assign count_full  = (token_count >= max_tokens);
  assign quote_close = (item.ch == (quote_is_double ? CH_DQUOTE : CH_SQUOTE));
  assign num_start   = item.is_digit || item.ch == CH_DOT;
  assign is_quote    = (item.ch == CH_DQUOTE) || (item.ch == CH_SQUOTE);
  assign num_cont    = num_start || item.ch == CH_LOW_E || item.ch == CH_UP_E ||
                       (exp_last && (item.ch == CH_PLUS || item.ch == CH_MINUS));
  assign name_cont   = item.is_alpha || item.is_digit || item.ch == CH_UNDER;

  always_comb begin
    mode_next = mode;
    if (go) begin
      if (item.end_of_string) begin
        mode_next = MODE_IDLE;
      end else if (error_latched == ST_OK) begin
        unique case (mode)
          MODE_QUOTED: begin
            if (quote_close || too_long) begin
              mode_next = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (num_cont) begin
              mode_next = too_long ? MODE_IDLE : MODE_NUMBER;
            end else begin
              mode_next = start_mode(item, count_full);
            end
          end
          MODE_NAME: begin
            if (name_cont) begin
              mode_next = too_long ? MODE_IDLE : MODE_NAME;
            end else begin
              mode_next = start_mode(item, count_full);
            end
          end
          MODE_IDLE: begin
            if (held_valid && item.ch == CH_STAR) begin
              mode_next = MODE_IDLE;
            end else begin
              mode_next = start_mode(item, count_full);
            end
          end
          default: mode_next = MODE_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    logic       do_start;
    logic [2:0] st;
    result_t    held_res;
    held_res = mk({1'b0, held_kind}, held_char, 1'b1, held_first, 1'b0, ST_OK, 1'b0);
    do_start = 1'b0;
    st       = error_latched;
    res[0]   = '0;
    res[1]   = '0;
    res_n    = 2'd0;
    quote_is_double_next = quote_is_double;
    exp_last_next        = exp_last;
    held_char_next       = held_char;
    held_valid_next      = held_valid;
    held_kind_next       = held_kind;
    held_first_next      = held_first;
    token_length_next    = token_length;
    token_count_next     = token_count;
    error_latched_next   = error_latched;
    if (go) begin
      if (item.end_of_string) begin
        if (error_latched == ST_OK) begin
          if (mode == MODE_QUOTED) begin
            st = ST_UNTERMINATED;
          end else if (held_valid) begin
            res[0]           = held_res;
            res[0].token_end = 1'b1;
            res_n            = 2'd1;
          end
        end
        res[res_n[0]] = mk(KIND_STATUS, 8'd0, 1'b0, 1'b0, 1'b0, st, 1'b1);
        res_n         = res_n + 2'd1;
        quote_is_double_next = 1'b0;
        exp_last_next        = 1'b0;
        held_char_next       = '0;
        held_valid_next      = 1'b0;
        held_kind_next       = '0;
        held_first_next      = 1'b0;
        token_length_next    = '0;
        token_count_next     = '0;
        error_latched_next   = ST_OK;
      end else if (error_latched == ST_OK) begin
        unique case (mode)
          MODE_QUOTED: begin
            if (quote_close) begin
              if (held_valid) begin
                res[0]           = held_res;
                res[0].token_end = 1'b1;
              end else begin
                res[0] = mk(KIND_QUOTED, 8'd0, 1'b0, 1'b1, 1'b1, ST_OK, 1'b0);
              end
              held_valid_next = 1'b0;
              res_n           = 2'd1;
            end else if (too_long) begin
              error_latched_next = ST_QUOTE_LONG;
              held_valid_next    = 1'b0;
              res[0] = mk(KIND_STATUS, 8'd0, 1'b0, 1'b0, 1'b0, ST_QUOTE_LONG, 1'b0);
              res_n  = 2'd1;
            end else begin
              if (held_valid) begin
                res[0] = held_res;
                res_n  = 2'd1;
              end
              held_char_next    = item.upper;
              held_kind_next    = KIND_QUOTED[1:0];
              held_first_next   = (token_length == '0);
              held_valid_next   = 1'b1;
              token_length_next = token_length + 8'd1;
            end
          end
          MODE_NUMBER, MODE_NAME: begin
            if ((mode == MODE_NUMBER) ? num_cont : name_cont) begin
              if (too_long) begin
                st = (mode == MODE_NUMBER) ? ST_NUM_LONG : ST_NAME_LONG;
                error_latched_next = st;
                held_valid_next    = 1'b0;
                res[0] = mk(KIND_STATUS, 8'd0, 1'b0, 1'b0, 1'b0, st, 1'b0);
                res_n  = 2'd1;
              end else begin
                res[0]            = held_res;
                res_n             = 2'd1;
                held_valid_next   = 1'b1;
                held_first_next   = 1'b0;
                token_length_next = token_length + 8'd1;
                if (mode == MODE_NUMBER) begin
                  held_char_next = item.ch;
                  held_kind_next = KIND_NUMBER[1:0];
                  exp_last_next  = (item.ch == CH_LOW_E) || (item.ch == CH_UP_E);
                end else begin
                  held_char_next = item.upper;
                  held_kind_next = KIND_NAME[1:0];
                end
              end
            end else begin
              res[0]           = held_res;
              res[0].token_end = 1'b1;
              res_n            = 2'd1;
              held_valid_next  = 1'b0;
              do_start         = 1'b1;
            end
          end
          MODE_IDLE: begin
            if (held_valid) begin
              held_valid_next = 1'b0;
              res_n           = 2'd1;
              if (item.ch == CH_STAR) begin
                res[0] = mk(KIND_SINGLE, CH_CARET, 1'b1, 1'b1, 1'b1, ST_OK, 1'b0);
              end else begin
                res[0]           = held_res;
                res[0].token_end = 1'b1;
                do_start         = 1'b1;
              end
            end else begin
              do_start = 1'b1;
            end
          end
          default: ;
        endcase
        if (do_start && !item.is_space) begin
          if (count_full) begin
            error_latched_next = ST_TOO_MANY;
            held_valid_next    = 1'b0;
            res[res_n[0]] = mk(KIND_STATUS, 8'd0, 1'b0, 1'b0, 1'b0, ST_TOO_MANY, 1'b0);
            res_n         = res_n + 2'd1;
          end else begin
            token_count_next = token_count + 9'd1;
            if (num_start) begin
              exp_last_next     = 1'b0;
              token_length_next = 8'd1;
              held_char_next    = item.ch;
              held_kind_next    = KIND_NUMBER[1:0];
              held_first_next   = 1'b1;
              held_valid_next   = 1'b1;
            end else if (item.is_alpha) begin
              token_length_next = 8'd1;
              held_char_next    = item.upper;
              held_kind_next    = KIND_NAME[1:0];
              held_first_next   = 1'b1;
              held_valid_next   = 1'b1;
            end else if (is_quote) begin
              quote_is_double_next = (item.ch == CH_DQUOTE);
              token_length_next    = '0;
              held_valid_next      = 1'b0;
            end else if (item.ch == CH_STAR) begin
              held_char_next  = item.ch;
              held_kind_next  = KIND_SINGLE[1:0];
              held_first_next = 1'b1;
              held_valid_next = 1'b1;
            end else begin
              res[res_n[0]] = mk(KIND_SINGLE, item.ch, 1'b1, 1'b1, 1'b1, ST_OK, 1'b0);
              res_n         = res_n + 2'd1;
            end
          end
        end
      end
      if (res_n != 2'd0) begin
        res[res_n[1]].last_result = 1'b1;
      end
    end
  end

  assign res0 = res[0];
  assign res1 = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens      <= MAX_TOKENS_RST;
      max_token_chars <= MAX_TOKEN_CHARS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_TOKENS) begin
        max_tokens <= cfg_data;
      end else if (cfg_index == CFG_MAX_TOKEN_CHARS) begin
        max_token_chars <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      quote_is_double <= 1'b0;
      exp_last        <= 1'b0;
      held_char       <= '0;
      held_valid      <= 1'b0;
      held_kind       <= '0;
      held_first      <= 1'b0;
      token_length    <= '0;
      token_count     <= '0;
      error_latched   <= ST_OK;
    end else begin
      mode            <= mode_next;
      quote_is_double <= quote_is_double_next;
      exp_last        <= exp_last_next;
      held_char       <= held_char_next;
      held_valid      <= held_valid_next;
      held_kind       <= held_kind_next;
      held_first      <= held_first_next;
      token_length    <= token_length_next;
      token_count     <= token_count_next;
      error_latched   <= error_latched_next;
    end
  end

endmodule

/* sv/etok_outq.sv */
module etok_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  etok_pkg::result_t d0,
  input  etok_pkg::result_t d1,
  output logic              room,
  output logic              empty,
  input  logic              pop,
  output etok_pkg::result_t q
);
  import etok_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  result_t       entry [OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign room   = (count <= CW'(OUTQ_DEPTH - 2));
  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign q      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry[wr_ptr] <= d0;
    end
    if (push_n == 2'd2) begin
      entry[wr_ptr + PW'(1)] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CW'(push_n) - CW'(do_pop);
    end
  end

endmodule

/* sv/expression_tokenizer.sv */
// Channel   Handshake                 Payload
// input     push / full               in_item  (ch, end_of_string)
// result    pop / empty               out_item (token fields, status, flags)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One character per cycle while the result queue has room; the lexer writes zero, one
// or two results per item into a four-entry result queue.
// The input queue registers each item, and the result queue registers its results.
// The lexer stalls while the result queue has fewer than two free entries;
// the two-entry input queue then fills and raises full.
// Reset clears queues, lexer state and sets both registers to their defaults.
module expression_tokenizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  etok_pkg::in_item_t              in_item,
  output logic                            empty,
  input  logic                            pop,
  output etok_pkg::result_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [etok_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etok_pkg::CFG_DATA_W-1:0] cfg_data
);
  import etok_pkg::*;

  class_item_t item;
  logic        item_valid;
  logic        item_take;
  logic        room;
  logic [1:0]  res_n;
  result_t     res0;
  result_t     res1;

  assign cfg_ready = 1'b1;

  etok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  etok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .room       (room),
    .res_n      (res_n),
    .res0       (res0),
    .res1       (res1)
  );

  etok_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push_n (res_n),
    .d0     (res0),
    .d1     (res1),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .q      (out_item)
  );

endmodule
